// ===== hw/rtl/pixel_background_subtractor_macros.svh =====
// assertion macros for the pixel background subtractor
// no dependencies; included by the files that carry assertions
`ifndef PIXEL_BACKGROUND_SUBTRACTOR_MACROS_SVH
`define PIXEL_BACKGROUND_SUBTRACTOR_MACROS_SVH
`ifndef SYNTHESIS
`define PBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pbs assertion failed");
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pbs assertion failed");
`else
`define PBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/pbs_pkg.sv =====
// shared types for the pixel background subtractor
// no dependencies; used by pbs_update, the top level, the scoreboard and the testbench
package pbs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DIFF_THRESHOLD   = 3'd0,
        REG_BLEND_WEIGHT     = 3'd1,
        REG_SELECTIVE_UPDATE = 3'd2,
        REG_GHOST_LIMIT      = 3'd3,
        REG_COLOR_MODE       = 3'd4,
        REG_UPDATE_MODE      = 3'd5
    } cfg_reg_t;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_PROCESS = 1'b1
    } action_t;

    typedef struct packed {
        logic [7:0] diff_threshold;
        logic [8:0] blend_weight;
        logic       selective_update;
        logic [7:0] ghost_limit;
        logic       color_mode;
        logic       update_mode;
    } cfg_t;

    typedef struct packed {
        logic       process;
        logic       in_range;
        logic       gray;
        logic [7:0] pix_first;
        logic [7:0] pix_second;
        logic [7:0] pix_third;
    } upd_req_t;

    typedef struct packed {
        logic        foreground;
        logic [23:0] model;
        logic        bg_we;
        logic        count_we;
        logic [7:0]  count;
    } upd_rsp_t;

endpackage

// ===== hw/rtl/pbs_update.sv =====
// per-pixel decision and model update for one request
// depends on pbs_pkg
module pbs_update
(
    input  pbs_pkg::cfg_t     cfg,
    input  pbs_pkg::upd_req_t req,
    input  logic [23:0]       bg_word,
    input  logic [7:0]        count_old,
    output pbs_pkg::upd_rsp_t rsp
);
    import pbs_pkg::*;

    localparam logic [8:0]  ALPHA_ONE   = 9'd256;
    localparam logic [16:0] BLEND_ROUND = 17'd128;
    localparam logic [7:0]  COUNT_MAX   = 8'd255;

    logic [7:0]  pix [3];
    logic [7:0]  bg [3];
    logic [7:0]  blended [3];
    logic [7:0]  diff [3];
    logic [16:0] acc [3];
    logic [8:0]  alpha;
    logic        fg;
    logic [7:0]  count_new;
    logic        absorb;
    logic [23:0] pix_word;
    logic [23:0] bg_used;
    logic [23:0] blend_word;

    always_comb
    begin
        pix[0] = req.pix_first;
        pix[1] = req.pix_second;
        pix[2] = req.pix_third;
        bg[0]  = bg_word[7:0];
        bg[1]  = req.gray ? 8'd0 : bg_word[15:8];
        bg[2]  = req.gray ? 8'd0 : bg_word[23:16];
        alpha  = (cfg.blend_weight > ALPHA_ONE) ? ALPHA_ONE : cfg.blend_weight;
        fg     = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            diff[c] = (pix[c] > bg[c]) ? (pix[c] - bg[c]) : (bg[c] - pix[c]);
            if (diff[c] > cfg.diff_threshold)
            begin
                fg = 1'b1;
            end
            acc[c] = 17'(alpha) * 17'(pix[c]) + 17'(ALPHA_ONE - alpha) * 17'(bg[c])
                     + BLEND_ROUND;
            blended[c] = acc[c][15:8];
        end

        pix_word   = {pix[2], pix[1], pix[0]};
        bg_used    = {bg[2], bg[1], bg[0]};
        blend_word = {blended[2], blended[1], blended[0]};

        if (!fg)
        begin
            count_new = 8'd0;
        end
        else if (count_old == COUNT_MAX)
        begin
            count_new = COUNT_MAX;
        end
        else
        begin
            count_new = count_old + 8'd1;
        end
        absorb = (count_new >= cfg.ghost_limit);

        rsp = '0;
        priority if (!req.in_range)
        begin
            rsp = '0;
        end
        else if (!req.process)
        begin
            rsp.model    = pix_word;
            rsp.bg_we    = 1'b1;
            rsp.count_we = 1'b1;
            rsp.count    = 8'd0;
        end
        else if (!cfg.update_mode)
        begin
            rsp.foreground = fg;
            rsp.bg_we      = 1'b1;
            rsp.model      = (fg && cfg.selective_update) ? bg_used : blend_word;
        end
        else
        begin
            rsp.foreground = fg;
            rsp.bg_we      = 1'b1;
            rsp.count_we   = 1'b1;
            rsp.count      = count_new;
            priority if (absorb)
            begin
                rsp.model = pix_word;
            end
            else if (!fg)
            begin
                rsp.model = blend_word;
            end
            else
            begin
                rsp.model = bg_used;
            end
        end
    end

endmodule

// ===== hw/rtl/pixel_background_subtractor.sv =====
// Per-pixel background subtractor. One request is taken every clock while pix_stall is low;
// its result waits in an output register, so one more request is taken while a result is
// stalled. The background and stationary count of every pixel live in two single-port-read,
// single-port-write synchronous memories of PIXELS entries: the read is issued at acceptance,
// the decision and write-back follow as the request moves on, and a bypass covers back-to-back
// requests to one pixel. The memories are not cleared after reset; a pixel must be loaded
// before it is processed. Configuration is written through cfg_we/cfg_index/cfg_data; the
// user must do so only while no request is in flight, which the block does not enforce.
// depends on pbs_pkg, pbs_update and pixel_background_subtractor_macros.svh
`include "pixel_background_subtractor_macros.svh"

module pixel_background_subtractor
#(
    parameter int PIXELS = 524288
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pix_valid,
    output logic                             pix_stall,
    input  logic                             action,
    input  logic [18:0]                      pixel_index,
    input  logic [7:0]                       blue,
    input  logic [7:0]                       green,
    input  logic [7:0]                       red,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic                             foreground,
    output logic [7:0]                       model_first,
    output logic [7:0]                       model_second,
    output logic [7:0]                       model_third,
    input  logic                             cfg_we,
    input  logic [pbs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pbs_pkg::*;

    localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    localparam logic [21:0] GRAY_W_BLUE  = 22'd1868;
    localparam logic [21:0] GRAY_W_GREEN = 22'd9617;
    localparam logic [21:0] GRAY_W_RED   = 22'd4899;
    localparam logic [21:0] GRAY_ROUND   = 22'd8192;

    logic [23:0]       bg_mem [PIXELS];
    logic [7:0]        count_mem [PIXELS];

    cfg_t              cfg_reg;
    logic              s1_valid_reg;
    upd_req_t          s1_req_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              fwd_bg_hit_reg;
    logic              fwd_count_hit_reg;
    logic [23:0]       last_bg_reg;
    logic [7:0]        last_count_reg;
    logic [23:0]       bg_rd_reg;
    logic [7:0]        count_rd_reg;
    logic              res_valid_reg;
    logic              foreground_reg;
    logic [23:0]       model_reg;

    logic              accept;
    logic              s1_move;
    logic [ADDR_W-1:0] addr_in;
    logic              in_range;
    logic [21:0]       gray_sum;
    upd_req_t          req_next;
    upd_rsp_t          rsp;
    logic [23:0]       bg_cur;
    logic [7:0]        count_cur;

    // handshake and pipeline advance
    assign s1_move   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign pix_stall = s1_valid_reg && !s1_move;
    assign accept    = pix_valid && !pix_stall;

    assign addr_in  = ADDR_W'(pixel_index);
    assign in_range = (32'(pixel_index) < 32'(PIXELS));

    assign gray_sum = GRAY_W_BLUE * 22'(blue) + GRAY_W_GREEN * 22'(green)
                      + GRAY_W_RED * 22'(red) + GRAY_ROUND;

    always_comb
    begin
        req_next.process  = (action_t'(action) == ACT_PROCESS);
        req_next.in_range = in_range;
        req_next.gray     = !cfg_reg.color_mode;
        if (cfg_reg.color_mode)
        begin
            req_next.pix_first  = blue;
            req_next.pix_second = green;
            req_next.pix_third  = red;
        end
        else
        begin
            req_next.pix_first  = gray_sum[21:14];
            req_next.pix_second = 8'd0;
            req_next.pix_third  = 8'd0;
        end
    end

    // write-back bypass
    assign bg_cur    = fwd_bg_hit_reg ? last_bg_reg : bg_rd_reg;
    assign count_cur = fwd_count_hit_reg ? last_count_reg : count_rd_reg;

    pbs_update u_update
    (
        .cfg       (cfg_reg),
        .req       (s1_req_reg),
        .bg_word   (bg_cur),
        .count_old (count_cur),
        .rsp       (rsp)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.diff_threshold   <= 8'd25;
            cfg_reg.blend_weight     <= 9'd13;
            cfg_reg.selective_update <= 1'b1;
            cfg_reg.ghost_limit      <= 8'd50;
            cfg_reg.color_mode       <= 1'b0;
            cfg_reg.update_mode      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIFF_THRESHOLD:   cfg_reg.diff_threshold   <= cfg_data[7:0];
                REG_BLEND_WEIGHT:     cfg_reg.blend_weight     <= cfg_data;
                REG_SELECTIVE_UPDATE: cfg_reg.selective_update <= cfg_data[0];
                REG_GHOST_LIMIT:      cfg_reg.ghost_limit      <= cfg_data[7:0];
                REG_COLOR_MODE:       cfg_reg.color_mode       <= cfg_data[0];
                REG_UPDATE_MODE:      cfg_reg.update_mode      <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            fwd_bg_hit_reg    <= 1'b0;
            fwd_count_hit_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg      <= 1'b1;
                fwd_bg_hit_reg    <= s1_move && rsp.bg_we && (s1_addr_reg == addr_in);
                fwd_count_hit_reg <= s1_move && rsp.count_we && (s1_addr_reg == addr_in);
            end
            else if (s1_move)
            begin
                s1_valid_reg      <= 1'b0;
                fwd_bg_hit_reg    <= 1'b0;
                fwd_count_hit_reg <= 1'b0;
            end

            if (s1_move)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= req_next;
            s1_addr_reg <= addr_in;
        end
        if (s1_move)
        begin
            last_bg_reg    <= rsp.model;
            last_count_reg <= rsp.count;
            foreground_reg <= rsp.foreground;
            model_reg      <= rsp.model;
        end
    end

    // background and count memories
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            bg_rd_reg    <= bg_mem[addr_in];
            count_rd_reg <= count_mem[addr_in];
        end
        if (s1_move && rsp.bg_we)
        begin
            bg_mem[s1_addr_reg] <= rsp.model;
        end
        if (s1_move && rsp.count_we)
        begin
            count_mem[s1_addr_reg] <= rsp.count;
        end
    end

    assign res_valid    = res_valid_reg;
    assign foreground   = foreground_reg;
    assign model_first  = model_reg[7:0];
    assign model_second = model_reg[15:8];
    assign model_third  = model_reg[23:16];

    `PBS_ASSERT_IMP(a_stall_only_busy, clk, rst_n, pix_stall, s1_valid_reg)
    `PBS_ASSERT_NEXT(a_move_fills_out, clk, rst_n, s1_move, res_valid_reg)
    `PBS_ASSERT_NEXT(a_load_is_bg, clk, rst_n, s1_move && !s1_req_reg.process, !foreground)
    `PBS_ASSERT_NEXT(a_gray_upper_zero, clk, rst_n, s1_move && s1_req_reg.gray, ~|model_reg[23:8])
    `PBS_ASSERT_IMP(a_fwd_needs_req, clk, rst_n, fwd_bg_hit_reg || fwd_count_hit_reg, s1_valid_reg)

endmodule

// ===== verif/bg_scoreboard_pkg.sv =====
// scoreboard for the pixel background subtractor: per-pixel background and
// stationary count mirror, expected result queue and field-wise result check
// depends on pbs_pkg
`timescale 1ns / 1ps

package bg_scoreboard_pkg;

    import pbs_pkg::*;

    typedef struct packed {
        logic       foreground;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
    } pixel_verdict_t;

    class bg_scoreboard;

        logic [7:0]     threshold;
        logic [8:0]     weight;
        logic           selective;
        logic [7:0]     ghost;
        logic           color;
        logic           suppress;
        logic [23:0]    bg_mem [int];
        logic [7:0]     still_count [int];
        pixel_verdict_t pending [$];
        int             errors;
        int             checked;

        function new();
            threshold = 8'd25;
            weight    = 9'd13;
            selective = 1'b1;
            ghost     = 8'd50;
            color     = 1'b0;
            suppress  = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [8:0] v);
            case (r)
                REG_DIFF_THRESHOLD:   threshold = v[7:0];
                REG_BLEND_WEIGHT:     weight    = v;
                REG_SELECTIVE_UPDATE: selective = v[0];
                REG_GHOST_LIMIT:      ghost     = v[7:0];
                REG_COLOR_MODE:       color     = v[0];
                REG_UPDATE_MODE:      suppress  = v[0];
                default: ;
            endcase
        endfunction

        function int blend_channel(int pix, int bg, int alpha);
            return (alpha * pix + (256 - alpha) * bg + 128) >> 8;
        endfunction

        function void note_request(action_t act, logic [18:0] idx,
                                   logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int             pix [3];
            int             bgc [3];
            int             nb [3];
            int             chans;
            int             alpha;
            int             cnt;
            int             diff;
            bit             fg;
            logic [23:0]    stored;
            pixel_verdict_t v;

            pix[0] = b;
            pix[1] = g;
            pix[2] = r;
            chans  = 3;
            fg     = 1'b0;
            if (!color)
            begin
                pix[0] = (1868 * b + 9617 * g + 4899 * r + 8192) >> 14;
                pix[1] = 0;
                pix[2] = 0;
                chans  = 1;
            end

            if (act == ACT_LOAD)
            begin
                nb = pix;
                still_count[idx] = 8'd0;
            end
            else
            begin
                stored = bg_mem.exists(idx) ? bg_mem[idx] : 24'd0;
                bgc[0] = stored[7:0];
                bgc[1] = stored[15:8];
                bgc[2] = stored[23:16];
                if (!color)
                begin
                    bgc[1] = 0;
                    bgc[2] = 0;
                end
                for (int c = 0; c < chans; c++)
                begin
                    diff = pix[c] > bgc[c] ? pix[c] - bgc[c] : bgc[c] - pix[c];
                    if (diff > int'(threshold))
                        fg = 1'b1;
                end
                alpha = weight > 9'd256 ? 256 : int'(weight);
                nb = bgc;
                if (!suppress)
                begin
                    if (!(fg && selective))
                        for (int c = 0; c < chans; c++)
                            nb[c] = blend_channel(pix[c], bgc[c], alpha);
                end
                else
                begin
                    cnt = still_count.exists(idx) ? int'(still_count[idx]) : 0;
                    if (fg)
                        cnt = cnt < 255 ? cnt + 1 : 255;
                    else
                        cnt = 0;
                    still_count[idx] = 8'(cnt);
                    if (cnt >= int'(ghost))
                    begin
                        for (int c = 0; c < chans; c++)
                            nb[c] = pix[c];
                    end
                    else if (!fg)
                    begin
                        for (int c = 0; c < chans; c++)
                            nb[c] = blend_channel(pix[c], bgc[c], alpha);
                    end
                end
            end

            bg_mem[idx]  = {8'(nb[2]), 8'(nb[1]), 8'(nb[0])};
            v.foreground = fg;
            v.first      = 8'(nb[0]);
            v.second     = 8'(nb[1]);
            v.third      = 8'(nb[2]);
            pending      = {pending, v};
        endfunction

        task report_mismatch(string what, int got, int wanted);
            $display("mismatch on result %0d, %s: got %0h, wanted %0h",
                     checked, what, got, wanted);
            errors++;
        endtask

        task check_result(logic fg, logic [7:0] first, logic [7:0] second,
                          logic [7:0] third);
            pixel_verdict_t want;

            checked++;
            if (pending.size() == 0)
            begin
                report_mismatch("no request outstanding", fg, 0);
                return;
            end
            want = pending.pop_front();
            if (fg !== want.foreground)
                report_mismatch("foreground", fg, want.foreground);
            if (first !== want.first)
                report_mismatch("model_first", first, want.first);
            if (second !== want.second)
                report_mismatch("model_second", second, want.second);
            if (third !== want.third)
                report_mismatch("model_third", third, want.third);
        endtask

    endclass

endpackage

// ===== verif/tb_top.sv =====
// testbench top for the pixel background subtractor: directed and random pixel
// streams under several register settings, random stalls on both sides
// depends on pbs_pkg, bg_scoreboard_pkg and the pixel_background_subtractor rtl
`timescale 1ns / 1ps

module tb_top;

    import pbs_pkg::*;
    import bg_scoreboard_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   pix_valid;
    logic                   pix_stall;
    logic                   action;
    logic [18:0]            pixel_index;
    logic [7:0]             blue;
    logic [7:0]             green;
    logic [7:0]             red;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    logic                   foreground;
    logic [7:0]             model_first;
    logic [7:0]             model_second;
    logic [7:0]             model_third;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    bg_scoreboard sb;
    bit           loaded [int];
    logic [18:0]  pool [12];
    bit           tx_idle = 1'b0;
    bit           rx_idle = 1'b0;
    int           holds_asked = 0;
    int           holds_done = 0;

    pixel_background_subtractor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .action       (action),
        .pixel_index  (pixel_index),
        .blue         (blue),
        .green        (green),
        .red          (red),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .foreground   (foreground),
        .model_first  (model_first),
        .model_second (model_second),
        .model_third  (model_third),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
            sb.check_result(foreground, model_first, model_second, model_third);
    end

    // result side: random stalls, or a long hold-off when asked
    initial
    begin : receive_side
        int hold_cycles;

        hold_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (holds_asked > holds_done)
            begin
                holds_done++;
                hold_cycles = 300;
            end
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles--;
            end
            else
                res_stall <= rx_idle && ($urandom_range(99) < 34);
        end
    end

    task automatic send_pixel(action_t act, logic [18:0] idx,
                              logic [7:0] b, logic [7:0] g, logic [7:0] r);
        bit taken;

        if (tx_idle)
        begin
            while ($urandom_range(99) < 34)
            begin
                pix_valid <= 1'b0;
                @(posedge clk);
            end
        end
        pix_valid   <= 1'b1;
        action      <= act;
        pixel_index <= idx;
        blue        <= b;
        green       <= g;
        red         <= r;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !pix_stall;
            @(posedge clk);
        end
        sb.note_request(act, idx, b, g, r);
        if (act == ACT_LOAD)
            loaded[idx] = 1'b1;
    endtask

    task automatic settle();
        pix_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apply_config(int thr, int bw, int sel, int gl, int color, int upd);
        logic [8:0] vals [6];

        vals = '{9'(thr), 9'(bw), 9'(sel), 9'(gl), 9'(color), 9'(upd)};
        for (int i = 0; i < 6; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_reg(cfg_reg_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic refresh_pool();
        for (int i = 6; i < 12; i++)
            pool[i] = 19'($urandom_range(0, 524287));
    endtask

    // mostly pixels close to the held background, some far off, some random
    task automatic random_item();
        logic [18:0] idx;
        logic [7:0]  ch [3];
        logic [7:0]  base;
        logic [23:0] held;
        action_t     act;
        int          shape;
        int          spread;
        int          v;

        idx = pool[$urandom_range(11)];
        act = (!loaded.exists(idx) || $urandom_range(99) < 8) ? ACT_LOAD : ACT_PROCESS;
        held = sb.bg_mem.exists(idx) ? sb.bg_mem[idx] : 24'd0;
        shape = $urandom_range(99);
        spread = int'(sb.threshold) + 3;
        for (int c = 0; c < 3; c++)
        begin
            base = sb.color ? held[8*c +: 8] : held[7:0];
            if (shape < 55)
            begin
                v = int'(base) + int'($urandom_range(2 * spread)) - spread;
                ch[c] = v < 0 ? 8'd0 : (v > 255 ? 8'd255 : 8'(v));
            end
            else if (shape < 75)
                ch[c] = 8'd255 - base;
            else
                ch[c] = 8'($urandom_range(255));
        end
        send_pixel(act, idx, ch[0], ch[1], ch[2]);
    endtask

    task automatic random_phase(int items);
        refresh_pool();
        for (int n = 0; n < items; n++)
            random_item();
        settle();
    endtask

    initial
    begin : main_sequence
        logic [7:0] px;

        sb          = new();
        rst_n       = 1'b0;
        pix_valid   = 1'b0;
        action      = 1'b0;
        pixel_index = '0;
        blue        = '0;
        green       = '0;
        red         = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        pool[0] = 19'd0;
        pool[1] = 19'h7FFFF;
        for (int i = 2; i < 6; i++)
            pool[i] = 19'($urandom_range(0, 524287));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;

        // gray, running average, selective
        apply_config(25, 13, 1, 50, 0, 0);
        send_pixel(ACT_LOAD, 19'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(ACT_LOAD, 19'h7FFFF, 8'd255, 8'd255, 8'd255);
        send_pixel(ACT_LOAD, 19'd1, 8'd100, 8'd100, 8'd100);
        send_pixel(ACT_PROCESS, 19'd0, 8'd255, 8'd255, 8'd255);
        send_pixel(ACT_PROCESS, 19'h7FFFF, 8'd255, 8'd255, 8'd255);
        send_pixel(ACT_PROCESS, 19'd1, 8'd125, 8'd125, 8'd125);
        send_pixel(ACT_PROCESS, 19'd1, 8'd200, 8'd200, 8'd200);
        send_pixel(ACT_PROCESS, 19'd1, 8'd0, 8'd255, 8'd0);
        settle();

        // colour over gray-loaded entry, weight beyond full, zero threshold
        apply_config(0, 511, 0, 0, 1, 0);
        send_pixel(ACT_PROCESS, 19'd1, 8'd10, 8'd20, 8'd30);
        send_pixel(ACT_LOAD, 19'd2, 8'd0, 8'd128, 8'd255);
        send_pixel(ACT_PROCESS, 19'd2, 8'd0, 8'd128, 8'd255);
        send_pixel(ACT_PROCESS, 19'd2, 8'd1, 8'd128, 8'd255);
        settle();

        // suppression with ghost limit zero
        apply_config(25, 128, 1, 0, 1, 1);
        send_pixel(ACT_PROCESS, 19'd2, 8'd255, 8'd0, 8'd0);
        send_pixel(ACT_PROCESS, 19'd2, 8'd255, 8'd0, 8'd0);
        send_pixel(ACT_PROCESS, 19'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(ACT_LOAD, 19'd2, 8'd9, 8'd9, 8'd9);
        settle();

        // gray suppression with ghost limit two, on a pixel that stays background
        apply_config(10, 64, 1, 2, 0, 1);
        send_pixel(ACT_PROCESS, 19'd1, 8'd0, 8'd0, 8'd0);
        send_pixel(ACT_PROCESS, 19'd1, 8'd0, 8'd0, 8'd0);
        send_pixel(ACT_PROCESS, 19'd1, 8'd0, 8'd0, 8'd0);
        send_pixel(ACT_PROCESS, 19'd1, 8'd0, 8'd0, 8'd0);
        settle();

        // receiver holds off while the sender keeps offering
        tx_idle = 1'b0;
        holds_asked++;
        apply_config(25, 13, 1, 3, 0, 1);
        random_phase(110);

        tx_idle = 1'b1;
        apply_config(255, 256, 0, 0, 1, 0);
        random_phase(110);

        apply_config(0, 0, 1, 255, 1, 1);
        random_phase(110);

        tx_idle = 1'b0;
        rx_idle = 1'b0;
        apply_config($urandom_range(5, 60), $urandom_range(0, 256), $urandom_range(1),
                     $urandom_range(1, 8), $urandom_range(1), $urandom_range(1));
        random_phase(100);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        apply_config($urandom_range(255), $urandom_range(0, 256), $urandom_range(1),
                     $urandom_range(255), $urandom_range(1), $urandom_range(1));
        random_phase(100);

        // count saturation: one pixel kept foreground well past the limit
        apply_config(100, 40, 1, 255, 0, 1);
        send_pixel(ACT_LOAD, pool[2], 8'd0, 8'd0, 8'd0);
        for (int n = 0; n < 270; n++)
        begin
            px = 8'd255 - sb.bg_mem[pool[2]][7:0];
            send_pixel(ACT_PROCESS, pool[2], px, px, px);
        end
        settle();

        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== pixel_background_subtractor.f =====
+incdir+hw/rtl
hw/rtl/pbs_pkg.sv
hw/rtl/pbs_update.sv
hw/rtl/pixel_background_subtractor.sv
verif/bg_scoreboard_pkg.sv
verif/tb_top.sv
